// ----- sv/versioned_char_buffer_with_undo_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef VERSIONED_CHAR_BUFFER_WITH_UNDO_TOP_DEFINES_SVH
`define VERSIONED_CHAR_BUFFER_WITH_UNDO_TOP_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define VCBU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define VCBU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/vcbu_pkg.sv -----
`timescale 1ns / 1ps

package vcbu_pkg;

    localparam int SPAN_LOG2 = 10;
    localparam int VERSIONS  = 1024;
    localparam int NODE_POOL = 16384;

    localparam int SPAN    = 1 << SPAN_LOG2;
    localparam int VER_W   = $clog2(VERSIONS + 1);
    localparam int NODE_W  = $clog2(NODE_POOL);
    localparam int LEN_W   = SPAN_LOG2 + 1;
    localparam int LVL_W   = $clog2(SPAN_LOG2 + 1);
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int FIELD_W = 11;

    // common width for compares between counts, lengths and version numbers
    localparam int CMP_A = (VER_W > FIELD_W) ? VER_W : FIELD_W;
    localparam int CMP_W = (CMP_A > LEN_W) ? CMP_A : LEN_W;

    // an append needs SPAN_LOG2+1 fresh nodes below NODE_POOL
    localparam int NODE_LIMIT = NODE_POOL - SPAN_LOG2 - 2;

    localparam logic [FUNC_W-1:0] OP_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] OP_UNDO   = 2'd1;
    localparam logic [FUNC_W-1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic latch_in;     // capture input transaction
        logic tbl_rd;       // read version tables
        logic tbl_sel_back; // table read address is the undo target
        logic a_start;      // append: new version entry, leaf write, root read
        logic u_write;      // undo: copy read entry into new version
        logic q_start;      // query: range check latch, root read
        logic step;         // descend one level
        logic step_wr;      // write copied path node during descent
        logic set_ovf;      // mark dropped append
        logic out_load;     // load result register
    } vcbu_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic              a_fail;
        logic              u_skip;
        logic              q_bad;
        logic              out_free;
    } vcbu_stat_t;

endpackage

// ----- sv/vcbu_ctrl.sv -----
`timescale 1ns / 1ps

module vcbu_ctrl import vcbu_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  vcbu_stat_t stat,
    output vcbu_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_A_CHECK  = 3'd2;
    localparam logic [2:0] S_A_WALK   = 3'd3;
    localparam logic [2:0] S_U_WRITE  = 3'd4;
    localparam logic [2:0] S_Q_CHECK  = 3'd5;
    localparam logic [2:0] S_Q_WALK   = 3'd6;
    localparam logic [2:0] S_EMIT     = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             lvl_last;

    assign lvl_last = (lvl_reg == LVL_W'(SPAN_LOG2 - 1));
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        lvl_next   = lvl_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat.op)
                    OP_APPEND: begin
                        cmd.tbl_rd = 1'b1;
                        state_next = S_A_CHECK;
                    end
                    OP_QUERY: begin
                        cmd.tbl_rd = 1'b1;
                        state_next = S_Q_CHECK;
                    end
                    OP_UNDO: begin
                        if (stat.u_skip) begin
                            state_next = S_IDLE;
                        end else begin
                            cmd.tbl_rd       = 1'b1;
                            cmd.tbl_sel_back = 1'b1;
                            state_next       = S_U_WRITE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_A_CHECK: begin
                if (stat.a_fail) begin
                    cmd.set_ovf = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    cmd.a_start = 1'b1;
                    lvl_next    = '0;
                    state_next  = S_A_WALK;
                end
            end
            S_A_WALK: begin
                cmd.step    = 1'b1;
                cmd.step_wr = 1'b1;
                lvl_next    = lvl_reg + LVL_W'(1);
                if (lvl_last) begin
                    state_next = S_IDLE;
                end
            end
            S_U_WRITE: begin
                cmd.u_write = 1'b1;
                state_next  = S_IDLE;
            end
            S_Q_CHECK: begin
                cmd.q_start = 1'b1;
                lvl_next    = '0;
                state_next  = stat.q_bad ? S_EMIT : S_Q_WALK;
            end
            S_Q_WALK: begin
                cmd.step = 1'b1;
                lvl_next = lvl_reg + LVL_W'(1);
                if (lvl_last) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lvl_reg   <= '0;
        end else begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
        end
    end

endmodule

// ----- sv/vcbu_dp.sv -----
`timescale 1ns / 1ps

module vcbu_dp import vcbu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  vcbu_cmd_t   cmd,
    output vcbu_stat_t  stat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [1:0]  m_tuser
);

    // captured transaction
    logic [FUNC_W-1:0]  op_reg;
    logic [CHAR_W-1:0]  ch_reg;
    logic [FIELD_W-1:0] cnt_reg;
    logic [FIELD_W-1:0] pos_reg;

    logic [VER_W-1:0]  cur_reg;
    logic [NODE_W-1:0] next_reg;
    logic              ovf_reg;

    // version tables
    logic [NODE_W-1:0] root_mem [0:VERSIONS];
    logic [LEN_W-1:0]  len_mem  [0:VERSIONS];
    logic [NODE_W-1:0] root_q_reg;
    logic [LEN_W-1:0]  len_q_reg;
    logic              tbl_zero_reg;
    logic [VER_W-1:0]  tbl_addr, back, cur_inc;
    logic [NODE_W-1:0] root_rd, wr_root;
    logic [LEN_W-1:0]  len_rd, wr_len;
    logic              tbl_we;
    logic [CMP_W-1:0]  cnt_x, cur_x;

    // node pool
    logic [NODE_W-1:0] left_mem  [0:NODE_POOL-1];
    logic [NODE_W-1:0] right_mem [0:NODE_POOL-1];
    logic [CHAR_W-1:0] leaf_mem  [0:NODE_POOL-1];
    logic [NODE_W-1:0] left_q_reg, right_q_reg;
    logic [CHAR_W-1:0] leaf_q_reg;
    logic              node_zero_reg;
    logic [NODE_W-1:0] left_rd, right_rd, node_raddr, dst_reg, dst_inc, leaf_addr;
    logic [CHAR_W-1:0] leaf_rd;
    logic              node_re;

    logic [SPAN_LOG2-1:0] key_reg;
    logic                 key_msb;
    logic                 q_bad_reg;

    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_char_reg;
    logic              m_status_reg;
    logic              m_ovf_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg  <= s_tuser[FUNC_W-1:0];
            ch_reg  <= s_tdata[7:0];
            cnt_reg <= s_tdata[18:8];
            pos_reg <= s_tdata[29:19];
        end
    end

    // entry 0 of each table and node 0 read as zero; they are never written
    assign root_rd  = tbl_zero_reg ? '0 : root_q_reg;
    assign len_rd   = tbl_zero_reg ? '0 : len_q_reg;
    assign left_rd  = node_zero_reg ? '0 : left_q_reg;
    assign right_rd = node_zero_reg ? '0 : right_q_reg;
    assign leaf_rd  = node_zero_reg ? '0 : leaf_q_reg;

    assign cnt_x    = CMP_W'(cnt_reg);
    assign cur_x    = CMP_W'(cur_reg);
    assign back     = (cnt_x > cur_x) ? '0 : VER_W'(cur_x - cnt_x);
    assign tbl_addr = cmd.tbl_sel_back ? back : cur_reg;
    assign cur_inc  = cur_reg + VER_W'(1);
    assign tbl_we   = cmd.a_start | cmd.u_write;
    assign wr_root  = cmd.a_start ? (next_reg + NODE_W'(1)) : root_rd;
    assign wr_len   = cmd.a_start ? (len_rd + LEN_W'(1)) : len_rd;

    always_ff @(posedge aclk) begin
        if (cmd.tbl_rd) begin
            root_q_reg   <= root_mem[tbl_addr];
            len_q_reg    <= len_mem[tbl_addr];
            tbl_zero_reg <= (tbl_addr == '0);
        end
        if (tbl_we) begin
            root_mem[cur_inc] <= wr_root;
            len_mem[cur_inc]  <= wr_len;
        end
    end

    // path direction: key bit 0 goes left, 1 goes right
    assign key_msb    = key_reg[SPAN_LOG2-1];
    assign node_re    = cmd.a_start | cmd.q_start | cmd.step;
    assign node_raddr = cmd.step ? (key_msb ? right_rd : left_rd) : root_rd;
    assign dst_inc    = dst_reg + NODE_W'(1);
    assign leaf_addr  = next_reg + NODE_W'(SPAN_LOG2 + 1);

    always_ff @(posedge aclk) begin
        if (node_re) begin
            left_q_reg    <= left_mem[node_raddr];
            right_q_reg   <= right_mem[node_raddr];
            leaf_q_reg    <= leaf_mem[node_raddr];
            node_zero_reg <= (node_raddr == '0);
        end
        if (cmd.step_wr) begin
            left_mem[dst_reg]  <= key_msb ? left_rd : dst_inc;
            right_mem[dst_reg] <= key_msb ? dst_inc : right_rd;
        end
        if (cmd.a_start) begin
            leaf_mem[leaf_addr] <= ch_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.a_start) begin
            dst_reg <= next_reg + NODE_W'(1);
            key_reg <= len_rd[SPAN_LOG2-1:0];
        end else if (cmd.q_start) begin
            key_reg <= SPAN_LOG2'(pos_reg - FIELD_W'(1));
        end else if (cmd.step) begin
            key_reg <= key_reg << 1;
            if (cmd.step_wr) begin
                dst_reg <= dst_inc;
            end
        end
        if (cmd.q_start) begin
            q_bad_reg <= stat.q_bad;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= '0;
            next_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            if (tbl_we) begin
                cur_reg <= cur_inc;
            end
            if (cmd.a_start) begin
                next_reg <= leaf_addr;
            end
            if (cmd.set_ovf) begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_char_reg   <= q_bad_reg ? '0 : leaf_rd;
            m_status_reg <= q_bad_reg;
            m_ovf_reg    <= ovf_reg;
        end
    end

    assign stat.op       = op_reg;
    assign stat.u_skip   = (cur_reg >= VER_W'(VERSIONS));
    assign stat.a_fail   = (cur_reg >= VER_W'(VERSIONS)) || (len_rd >= LEN_W'(SPAN)) ||
                           (int'(next_reg) > NODE_LIMIT);
    assign stat.q_bad    = (pos_reg == '0) || (CMP_W'(pos_reg) > CMP_W'(len_rd));
    assign stat.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tuser  = {m_ovf_reg, m_status_reg};

endmodule

// ----- sv/versioned_char_buffer_with_undo_top.sv -----
`timescale 1ns / 1ps
// Flow: one transaction at a time; the ten-level tree walk costs one dependent
// node read a cycle.
// Reset: synchronous active-low aresetn; empty version 0, node pointer and overflow cleared at once.
// Table entry 0 and node 0 read as zero, so no memory clearing pass is needed.

module versioned_char_buffer_with_undo_top import vcbu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // char_in[7:0], undo_count[18:8], position[29:19], zero
    input  logic [1:0]  s_tuser,  // func[1:0]
    // query results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // char_out[7:0]
    output logic [1:0]  m_tuser   // status[0], overflow[1]
);

    // Controller sequences each transaction; datapath holds the version tables,
    // the node pool and the result register. Only ready is exposed from the
    // controller: the block takes a transaction only when idle, while a finished
    // result may still sit in the output register waiting for m_tready.
    vcbu_cmd_t  cmd;
    vcbu_stat_t stat;

    vcbu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Append copies the root-to-leaf path: one node written per cycle while the
    // next source node is read. Query follows a root-to-leaf path read-only.
    vcbu_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- sv/vcbu_checker.sv -----
`timescale 1ns / 1ps
`include "versioned_char_buffer_with_undo_top_defines.svh"

module vcbu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled input transaction holds valid and payload
    `VCBU_ASSERT(a_in_hold, aclk, aresetn, s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser), "stalled input changed")
    // stalled result holds valid and payload
    `VCBU_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    // one transaction at a time: ready drops right after acceptance
    `VCBU_ASSERT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "ready held after acceptance")
    // a new result is only loaded while the input side is busy
    `VCBU_ASSERT(a_result_from_work, aclk, aresetn, $rose(m_tvalid) |-> !$past(s_tready), "result without work")
    // reset empties the result register
    `VCBU_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind versioned_char_buffer_with_undo_top vcbu_checker u_vcbu_checker (.*);
